[sv/ecc_pkg.sv]
package ecc_pkg;

	// Shaft geometry.
	localparam int MAX_FLOORS  = 16;
	localparam int FLOOR_UNITS = 4;

	// Field and register widths.
	localparam int FLOOR_W    = $clog2(MAX_FLOORS);
	localparam int TOP_W      = 4;
	localparam int SPEED_W    = 3;
	localparam int TICK_W     = 8;
	localparam int POS_W      = 6;
	localparam int ARITH_W    = 8;
	localparam int EST_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Divider by car speed: one quotient bit per cycle.
	localparam int DIV_W     = POS_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Car state codes.
	localparam logic [2:0] CAR_IDLE    = 3'd0;
	localparam logic [2:0] CAR_MOVING  = 3'd1;
	localparam logic [2:0] CAR_OPENING = 3'd2;
	localparam logic [2:0] CAR_OPEN    = 3'd3;
	localparam logic [2:0] CAR_CLOSING = 3'd4;
	localparam logic [2:0] CAR_WAIT    = 3'd5;

	// Direction codes.
	localparam logic [1:0] HEADING_NONE = 2'd0;
	localparam logic [1:0] HEADING_UP   = 2'd1;
	localparam logic [1:0] HEADING_DOWN = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAR_SPEED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPENING_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSING_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS    = 3'd5;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic accept;
		logic scan_clear;
		logic scan_step;
		logic step;
		logic div_start_t;
		logic div_start_l;
		logic div_step;
		logic load_out;
	} ecc_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic scan_last;
		logic div_last;
	} ecc_sts_t;

endpackage

[sv/ecc_datapath.sv]
module ecc_datapath import ecc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ecc_cmd_t                cmd,
	output ecc_sts_t                sts,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    request_valid,
	input  logic [3:0]              request_floor,
	input  logic [3:0]              query_floor,
	output logic [2:0]              car_state,
	output logic [1:0]              car_direction,
	output logic [POS_W-1:0]        car_position,
	output logic signed [EST_W-1:0] service_estimate
);

	// Shaft position of a floor.
	function automatic logic [ARITH_W-1:0] floor_pos(input logic [FLOOR_W-1:0] f);
		floor_pos = ARITH_W'(f * FLOOR_UNITS);
	endfunction

	// Configuration registers.
	logic [TOP_W-1:0]   top_floor_q;
	logic [SPEED_W-1:0] car_speed_q;
	logic [TICK_W-1:0]  opening_ticks_q;
	logic [TICK_W-1:0]  open_ticks_q;
	logic [TICK_W-1:0]  closing_ticks_q;
	logic [TICK_W-1:0]  wait_ticks_q;

	// Car state.
	logic [MAX_FLOORS-1:0] marks_q;
	logic [POS_W-1:0]      pos_q;
	logic [1:0]            dir_q;
	logic [2:0]            state_q;
	logic [TICK_W-1:0]     timer_q;
	logic [3:0]            query_q;

	// Scan accumulators.
	logic [FLOOR_W-1:0] scan_f_q;
	logic               up_found_q, dn_found_q, hi_found_q, lo_found_q;
	logic [FLOOR_W-1:0] up_f_q, dn_f_q, hi_f_q, lo_f_q;

	// Divider and estimate terms.
	logic [SPEED_W:0]    div_rem_q;
	logic [DIV_W-1:0]    div_quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIV_W-1:0]    tmag_q;
	logic                d_neg_q, d_pos_q;

	logic [FLOOR_W-1:0] eff_top;
	logic [SPEED_W-1:0] eff_speed;
	logic [ARITH_W-1:0] pos_ext;
	logic [ARITH_W-1:0] lim;

	assign eff_top   = (top_floor_q > TOP_W'(MAX_FLOORS - 1)) ? FLOOR_W'(MAX_FLOORS - 1)
	                                                          : FLOOR_W'(top_floor_q);
	assign eff_speed = (car_speed_q == '0) ? SPEED_W'(1) : car_speed_q;
	assign pos_ext   = ARITH_W'(pos_q);
	assign lim       = floor_pos(eff_top);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_floor_q     <= TOP_W'(15);
			car_speed_q     <= SPEED_W'(1);
			opening_ticks_q <= TICK_W'(2);
			open_ticks_q    <= TICK_W'(5);
			closing_ticks_q <= TICK_W'(2);
			wait_ticks_q    <= TICK_W'(2);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TOP_FLOOR:     top_floor_q     <= cfg_data[TOP_W-1:0];
				CFG_CAR_SPEED:     car_speed_q     <= cfg_data[SPEED_W-1:0];
				CFG_OPENING_TICKS: opening_ticks_q <= cfg_data;
				CFG_OPEN_TICKS:    open_ticks_q    <= cfg_data;
				CFG_CLOSING_TICKS: closing_ticks_q <= cfg_data;
				CFG_WAIT_TICKS:    wait_ticks_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// One floor of the stop scan per cycle.
	logic               scan_mark;
	logic [ARITH_W-1:0] scan_pos;

	assign scan_pos  = floor_pos(scan_f_q);
	assign scan_mark = marks_q[scan_f_q] && (scan_f_q <= eff_top);

	assign sts.scan_last = (scan_f_q == FLOOR_W'(MAX_FLOORS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_f_q   <= '0;
			up_found_q <= 1'b0;
			dn_found_q <= 1'b0;
			hi_found_q <= 1'b0;
			lo_found_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			scan_f_q   <= '0;
			up_found_q <= 1'b0;
			dn_found_q <= 1'b0;
			hi_found_q <= 1'b0;
			lo_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_f_q <= scan_f_q + FLOOR_W'(1);
			// Lowest mark at or above the car.
			if (scan_mark && scan_pos >= pos_ext && !up_found_q) begin
				up_found_q <= 1'b1;
			end
			// Highest mark at or below the car.
			if (scan_mark && scan_pos <= pos_ext) begin
				dn_found_q <= 1'b1;
			end
			// Highest mark strictly above the car.
			if (scan_mark && scan_pos > pos_ext) begin
				hi_found_q <= 1'b1;
			end
			// Lowest mark strictly below the car.
			if (scan_mark && scan_pos < pos_ext && !lo_found_q) begin
				lo_found_q <= 1'b1;
			end
		end
	end

	// Floor numbers found by the scan.
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (scan_mark && scan_pos >= pos_ext && !up_found_q) begin
				up_f_q <= scan_f_q;
			end
			if (scan_mark && scan_pos <= pos_ext) begin
				dn_f_q <= scan_f_q;
			end
			if (scan_mark && scan_pos > pos_ext) begin
				hi_f_q <= scan_f_q;
			end
			if (scan_mark && scan_pos < pos_ext && !lo_found_q) begin
				lo_f_q <= scan_f_q;
			end
		end
	end

	// Tick step of the car state machine, using the scan taken before it.
	logic [TICK_W-1:0]  t1;
	logic               chosen_found;
	logic [ARITH_W-1:0] chosen_pos;
	logic [1:0]         head_dir;
	logic [FLOOR_W-1:0] pos_floor;
	logic               at_marked;
	logic [ARITH_W-1:0] pos_up, pos_dn, pos_raw;
	logic [POS_W-1:0]   pos_moved;
	logic               keep_dir;
	logic [2:0]         state_n;
	logic [1:0]         dir_n;
	logic [POS_W-1:0]   pos_n;
	logic [TICK_W-1:0]  timer_n;
	logic               clear_mark;

	assign t1           = timer_q + TICK_W'(1);
	assign chosen_found = dn_found_q || up_found_q;
	assign chosen_pos   = dn_found_q ? floor_pos(dn_f_q) : floor_pos(up_f_q);
	assign head_dir     = (chosen_pos > pos_ext) ? HEADING_UP :
	                      (chosen_pos < pos_ext) ? HEADING_DOWN : dir_q;
	assign pos_floor    = FLOOR_W'(pos_q / FLOOR_UNITS);
	assign at_marked    = ((pos_q % FLOOR_UNITS) == 0) && (pos_floor <= eff_top) &&
	                      marks_q[pos_floor];
	assign keep_dir     = (dir_q == HEADING_UP && up_found_q) ||
	                      (dir_q == HEADING_DOWN && dn_found_q);

	// Move by the speed, held inside the shaft.
	assign pos_up    = pos_ext + ARITH_W'(eff_speed);
	assign pos_dn    = (pos_ext < ARITH_W'(eff_speed)) ? '0 : pos_ext - ARITH_W'(eff_speed);
	assign pos_raw   = (dir_q == HEADING_UP) ? pos_up : pos_dn;
	assign pos_moved = (pos_raw > lim) ? lim[POS_W-1:0] : pos_raw[POS_W-1:0];

	always_comb begin
		state_n    = state_q;
		dir_n      = dir_q;
		pos_n      = pos_q;
		timer_n    = t1;
		clear_mark = 1'b0;
		unique case (state_q)
			CAR_IDLE: begin
				if (chosen_found) begin
					state_n = CAR_MOVING;
					timer_n = '0;
					dir_n   = head_dir;
				end
			end
			CAR_MOVING: begin
				if (at_marked) begin
					clear_mark = 1'b1;
					state_n    = CAR_OPENING;
					timer_n    = '0;
				end else if (dir_q == HEADING_UP || dir_q == HEADING_DOWN) begin
					pos_n = pos_moved;
				end
			end
			CAR_OPENING: begin
				if (t1 == opening_ticks_q) begin
					state_n = CAR_OPEN;
					timer_n = '0;
				end
			end
			CAR_OPEN: begin
				if (t1 == open_ticks_q) begin
					state_n = CAR_CLOSING;
					timer_n = '0;
				end
			end
			CAR_CLOSING: begin
				if (t1 == closing_ticks_q) begin
					state_n = CAR_WAIT;
					timer_n = '0;
				end
			end
			CAR_WAIT: begin
				if (t1 == wait_ticks_q) begin
					timer_n = '0;
					if (chosen_found) begin
						state_n = CAR_MOVING;
						if (!keep_dir) begin
							dir_n = head_dir;
						end
					end else begin
						state_n = CAR_IDLE;
						dir_n   = HEADING_NONE;
					end
				end
			end
			default: begin
				// Unused codes fall back to idle.
				state_n = CAR_IDLE;
				dir_n   = HEADING_NONE;
				timer_n = '0;
			end
		endcase
	end

	// Car state registers and stop marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			pos_q   <= '0;
			dir_q   <= HEADING_NONE;
			state_q <= CAR_IDLE;
			timer_q <= '0;
		end else begin
			if (cmd.accept && request_valid && (FLOOR_W'(request_floor) <= eff_top)) begin
				marks_q[FLOOR_W'(request_floor)] <= 1'b1;
			end
			if (cmd.step) begin
				if (clear_mark) begin
					marks_q[pos_floor] <= 1'b0;
				end
				pos_q   <= pos_n;
				dir_q   <= dir_n;
				state_q <= state_n;
				timer_q <= timer_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			query_q <= query_floor;
		end
	end

	// Estimate terms after the step: query distance and last-stop distance.
	logic signed [ARITH_W-1:0] d;
	logic [DIV_W-1:0]          d_mag;
	logic [DIV_W-1:0]          lsd;

	assign d     = $signed(floor_pos(FLOOR_W'(query_q))) - $signed(pos_ext);
	assign d_mag = (d < 0) ? DIV_W'(-d) : DIV_W'(d);

	always_comb begin
		lsd = '0;
		if (state_q != CAR_IDLE) begin
			if (dir_q == HEADING_UP && hi_found_q) begin
				lsd = DIV_W'(floor_pos(hi_f_q) - pos_ext);
			end else if (dir_q == HEADING_DOWN && lo_found_q) begin
				lsd = DIV_W'(pos_ext - floor_pos(lo_f_q));
			end
		end
	end

	// Restoring divider by the car speed.
	logic [SPEED_W:0] div_shift;
	logic             div_fit;

	assign div_shift    = {div_rem_q[SPEED_W-1:0], div_quo_q[DIV_W-1]};
	assign div_fit      = div_shift >= {1'b0, eff_speed};
	assign sts.div_last = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start_t || cmd.div_start_l) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start_t) begin
			div_rem_q <= '0;
			div_quo_q <= d_mag;
			d_neg_q   <= (d < 0);
			d_pos_q   <= (d > 0);
		end else if (cmd.div_start_l) begin
			tmag_q    <= div_quo_q;
			div_rem_q <= '0;
			div_quo_q <= lsd;
		end else if (cmd.div_step) begin
			div_rem_q <= div_fit ? (div_shift - {1'b0, eff_speed}) : div_shift;
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_fit};
		end
	end

	// Final estimate and the result register.
	logic signed [EST_W-1:0] t_s;
	logic signed [EST_W-1:0] lq2;
	logic                    easy;
	logic signed [EST_W-1:0] est;

	assign t_s  = d_neg_q ? -$signed(EST_W'(tmag_q)) : $signed(EST_W'(tmag_q));
	assign lq2  = $signed(EST_W'({div_quo_q, 1'b0}));
	assign easy = (state_q == CAR_IDLE) || (d_pos_q && dir_q == HEADING_UP) ||
	              (d_neg_q && dir_q == HEADING_DOWN);
	assign est  = easy ? -t_s : (lq2 + t_s);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			car_state        <= state_q;
			car_direction    <= dir_q;
			car_position     <= pos_q;
			service_estimate <= est;
		end
	end

endmodule

[sv/ecc_ctrl.sv]
module ecc_ctrl import ecc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ecc_sts_t sts,
	output ecc_cmd_t cmd
);

	localparam logic [3:0] SQ_IDLE      = 4'd0;
	localparam logic [3:0] SQ_SCAN_PRE  = 4'd1;
	localparam logic [3:0] SQ_STEP      = 4'd2;
	localparam logic [3:0] SQ_SCAN_POST = 4'd3;
	localparam logic [3:0] SQ_PREP_T    = 4'd4;
	localparam logic [3:0] SQ_DIV_T     = 4'd5;
	localparam logic [3:0] SQ_PREP_L    = 4'd6;
	localparam logic [3:0] SQ_DIV_L     = 4'd7;
	localparam logic [3:0] SQ_LOAD      = 4'd8;

	logic [3:0] sq_q, sq_n;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (sq_q == SQ_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Sequencer for one tick: scan, step, scan, two divisions, result load.
	always_comb begin
		sq_n = sq_q;
		cmd  = '0;
		unique case (sq_q)
			SQ_IDLE: begin
				if (in_valid) begin
					cmd.accept     = 1'b1;
					cmd.scan_clear = 1'b1;
					sq_n           = SQ_SCAN_PRE;
				end
			end
			SQ_SCAN_PRE: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					sq_n = SQ_STEP;
				end
			end
			SQ_STEP: begin
				cmd.step       = 1'b1;
				cmd.scan_clear = 1'b1;
				sq_n           = SQ_SCAN_POST;
			end
			SQ_SCAN_POST: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					sq_n = SQ_PREP_T;
				end
			end
			SQ_PREP_T: begin
				cmd.div_start_t = 1'b1;
				sq_n            = SQ_DIV_T;
			end
			SQ_DIV_T: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					sq_n = SQ_PREP_L;
				end
			end
			SQ_PREP_L: begin
				cmd.div_start_l = 1'b1;
				sq_n            = SQ_DIV_L;
			end
			SQ_DIV_L: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					sq_n = SQ_LOAD;
				end
			end
			SQ_LOAD: begin
				// The finished result waits here for a free output register.
				if (out_free) begin
					cmd.load_out = 1'b1;
					sq_n         = SQ_IDLE;
				end
			end
			default: begin
				sq_n = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q        <= SQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			sq_q <= sq_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/elevator_car_controller.sv]
// Lift car controller: one input transfer is one simulation tick of the car.
// Input channel (in_valid/in_ready): request_valid/request_floor optionally
// mark a stop, query_floor selects the call floor for the service estimate.
// Output channel (out_valid/out_ready): state, direction and position after
// the tick, and the signed service estimate for the queried floor.
// Configuration: cfg_write with cfg_index/cfg_data sets one register per
// cycle; write only while no tick is in flight.
// Per tick: a stop scan over all floors before the step, the step itself, a
// second scan after it, and two divisions by the car speed on one shared
// divider (one quotient bit per cycle, one setup state each), then a load
// state. A new tick is accepted only once the last one has been loaded.
// A finished result sits in an output register; the next tick is taken while
// it waits. If the receiver stalls, the following tick holds in its load
// cycle until the output register frees.
// Reset clears the stop marks, puts the car idle at the ground floor with no
// direction and a zero timer, and restores the register defaults.
module elevator_car_controller import ecc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    request_valid,
	input  logic [3:0]              request_floor,
	input  logic [3:0]              query_floor,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              car_state,
	output logic [1:0]              car_direction,
	output logic [POS_W-1:0]        car_position,
	output logic signed [EST_W-1:0] service_estimate
);

	ecc_cmd_t cmd;
	ecc_sts_t sts;

	ecc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ecc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.request_valid    (request_valid),
		.request_floor    (request_floor),
		.query_floor      (query_floor),
		.car_state        (car_state),
		.car_direction    (car_direction),
		.car_position     (car_position),
		.service_estimate (service_estimate)
	);

	// At most one major command is issued in any cycle.
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.step, cmd.div_start_t, cmd.div_start_l, cmd.load_out}))
		else $error("sequencer issued overlapping commands");

	// A transfer in closes the input channel for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready while a tick is in flight");

	// Loading a result always presents it on the output channel.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result loaded but not presented");

	// A result is only loaded when the output register is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result overwrote a pending transfer");

endmodule
